// ----- rtl/core/esr_pkg.sv -----
// Package for the encoder speed step regulator.
// Holds the shared widths, codes and the controller/datapath handshake structs.
// No dependencies.
package esr_pkg;

   localparam int COUNT_BITS_DEF = 32;
   localparam int DUTY_MAX_DEF   = 255;
   localparam int DIV_BITS       = 32;
   localparam int DRIVE_BITS     = 11;
   localparam int POWER_BITS     = 10;
   localparam int INTERVAL_BITS  = 16;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REQ_DATA_BITS  = 40;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_DATA_BITS  = 80;
   localparam int RSP_USER_BITS  = 2;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_EDGE   = 2'd0;
   localparam mode_type MODE_SAMPLE = 2'd1;
   localparam mode_type MODE_CLEAR  = 2'd2;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_MAX_POWER    = 3'd0,
      CSR_ADJUST_STEP  = 3'd1,
      CSR_MIN_INTERVAL = 3'd2,
      CSR_INVERT       = 3'd3,
      CSR_TARGET_SPEED = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic count_edge;
      logic count_clear;
      logic diff;
      logic scale;
      logic spd_start;
      logic spd_load;
      logic drive_up;
      logic drive_down;
      logic drive_zero;
      logic map;
      logic prod;
      logic duty_start;
      logic duty_load;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     interval_ok;
      logic     target_zero;
      logic     speed_lt;
      logic     speed_gt;
      logic     div_done;
   } stat_type;

endpackage

// ----- rtl/core/encoder_speed_step_regulator_top.sv -----
// Top level of the encoder speed step regulator.
// Depends on esr_pkg; instantiates esr_ctrl and esr_datapath.
//
// Each request beat is one event: an encoder edge, a timed control sample or
// a count clear, selected by req_tuser. Every request yields exactly one
// response beat with the held duty and direction, the last measured speed,
// the corrected encoder count and two flags in rsp_tuser.
// Settings are to be written through csr_we, csr_addr and csr_wdata only while
// idle; the user must keep to this, as the block itself does not enforce it.
// An edge, a clear or an unused mode goes from the decode state straight to the
// finish state, and a skipped sample passes the interval check first. An
// acted-on sample computes the speed quotient, and when the drive is rewritten
// also the duty scaling; each passes through one shared divider that produces
// one quotient bit per cycle.
// One item is processed at a time; a new request can be accepted once the
// previous result sits in the output register, even if it is not yet taken.
// When the receiver stalls, that response is held and the next finished
// item waits until the output register is free.
// Synchronous reset clears the count, speed, drive and settings to their
// defaults and drops rsp_tvalid.
module encoder_speed_step_regulator_top import esr_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int DUTY_MAX   = DUTY_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0: line_a, line_b, time_ms, zero padding.
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // Fields from bit 0: mode.
   input  logic [REQ_USER_BITS-1:0] req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // Fields from bit 0: pwm_duty, direction, speed, count, zero padding.
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // Fields from bit 0: sample_taken, drive_written.
   output logic [RSP_USER_BITS-1:0] rsp_tuser,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type     cmd;
   stat_type    stat;
   logic [7:0]  pwm_duty;
   logic        direction;
   logic [31:0] speed;
   logic [31:0] count;
   logic        sample_taken;
   logic        drive_written;

   esr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   esr_datapath #(
      .COUNT_BITS (COUNT_BITS),
      .DUTY_MAX   (DUTY_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .in_mode           (req_tuser[1:0]),
      .in_line_a         (req_tdata[0]),
      .in_line_b         (req_tdata[1]),
      .in_time_ms        (req_tdata[33:2]),
      .cmd               (cmd),
      .stat              (stat),
      .out_pwm_duty      (pwm_duty),
      .out_direction     (direction),
      .out_speed         (speed),
      .out_count         (count),
      .out_sample_taken  (sample_taken),
      .out_drive_written (drive_written)
   );

   assign rsp_tdata = {7'd0, count, speed, direction, pwm_duty};
   assign rsp_tuser = {drive_written, sample_taken};

endmodule

// ----- rtl/core/esr_div.sv -----
// Serial restoring divider, unsigned, one quotient bit per cycle.
// Depends on esr_pkg for the operand width.
module esr_div import esr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0] divisor,
   output logic                done,
   output logic [DIV_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic [DIV_BITS-1:0] rem_ff;
   logic [DIV_BITS-1:0] quo_ff;
   logic [DIV_BITS-1:0] dvs_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   logic [DIV_BITS:0]   shifted_in;
   logic [DIV_BITS:0]   trial_in;

   always_comb begin
      shifted_in = {rem_ff, quo_ff[DIV_BITS-1]};
      trial_in   = shifted_in - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(DIV_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!trial_in[DIV_BITS]) begin
            rem_ff <= trial_in[DIV_BITS-1:0];
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= shifted_in[DIV_BITS-1:0];
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/esr_datapath.sv -----
// Datapath of the regulator: settings, encoder count, speed and drive registers.
// Depends on esr_pkg and instantiates the serial divider esr_div.
module esr_datapath import esr_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int DUTY_MAX   = DUTY_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  mode_type                 in_mode,
   input  logic                     in_line_a,
   input  logic                     in_line_b,
   input  logic [31:0]              in_time_ms,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic [7:0]               out_pwm_duty,
   output logic                     out_direction,
   output logic [31:0]              out_speed,
   output logic [31:0]              out_count,
   output logic                     out_sample_taken,
   output logic                     out_drive_written
);

   localparam int PROD_BITS = POWER_BITS + $clog2(DUTY_MAX + 1);

   logic [POWER_BITS-1:0]    max_power_ff;
   logic [POWER_BITS-1:0]    adjust_step_ff;
   logic [INTERVAL_BITS-1:0] min_interval_ff;
   logic                     invert_ff;
   logic [31:0]              target_ff;

   mode_type                 mode_ff;
   logic                     line_a_ff;
   logic                     line_b_ff;
   logic [31:0]              time_ff;

   logic [COUNT_BITS-1:0]    raw_count_ff;
   logic [31:0]              prev_count_ff;
   logic [31:0]              prev_time_ff;
   logic [31:0]              speed_ff;
   logic [DRIVE_BITS-1:0]    drive_ff;
   logic [7:0]               duty_ff;
   logic                     dir_ff;

   logic [31:0]              cur_ff;
   logic [31:0]              delta_ff;
   logic [31:0]              diff_ff;
   logic [31:0]              num_ff;
   logic                     neg_ff;
   logic                     den_zero_ff;
   logic                     dir_next_ff;
   logic [POWER_BITS-1:0]    mag_ff;
   logic [PROD_BITS-1:0]     prod_ff;
   logic                     taken_ff;
   logic                     written_ff;

   logic [7:0]               rsp_duty_ff;
   logic                     rsp_dir_ff;
   logic [31:0]              rsp_speed_ff;
   logic [31:0]              rsp_count_ff;
   logic                     rsp_taken_ff;
   logic                     rsp_written_ff;

   logic [31:0]              raw_ext;
   logic [31:0]              logical_in;
   logic [31:0]              scaled_in;
   logic [DIV_BITS-1:0]      div_a_in;
   logic [DIV_BITS-1:0]      div_b_in;
   logic                     div_done;
   logic [DIV_BITS-1:0]      div_q;
   logic [31:0]              q_signed_in;
   logic [DRIVE_BITS:0]      drive_x_in;
   logic [DRIVE_BITS:0]      lim_in;
   logic [DRIVE_BITS:0]      nlim_in;
   logic [DRIVE_BITS:0]      up_in;
   logic [DRIVE_BITS:0]      down_in;
   logic [DRIVE_BITS:0]      clamp_in;
   logic [DRIVE_BITS:0]      pol_in;
   logic [DRIVE_BITS:0]      abs_in;

   if (COUNT_BITS >= 32) begin : g_count_wide
      assign raw_ext = raw_count_ff[31:0];
   end else begin : g_count_narrow
      assign raw_ext = {{(32 - COUNT_BITS){raw_count_ff[COUNT_BITS-1]}}, raw_count_ff};
   end

   always_comb begin
      logical_in  = invert_ff ? (32'd0 - raw_ext) : raw_ext;
      scaled_in   = (diff_ff << 10) - (diff_ff << 4) - (diff_ff << 3);
      q_signed_in = neg_ff ? (32'd0 - div_q) : div_q;
      if (cmd.duty_start) begin
         div_a_in = DIV_BITS'(prod_ff);
         div_b_in = DIV_BITS'(max_power_ff);
      end else begin
         div_a_in = num_ff[31] ? (32'd0 - num_ff) : num_ff;
         div_b_in = delta_ff[31] ? (32'd0 - delta_ff) : delta_ff;
      end
      drive_x_in = {drive_ff[DRIVE_BITS-1], drive_ff};
      lim_in     = (DRIVE_BITS + 1)'(max_power_ff);
      nlim_in    = '0 - lim_in;
      up_in      = drive_x_in + (DRIVE_BITS + 1)'(adjust_step_ff);
      down_in    = drive_x_in - (DRIVE_BITS + 1)'(adjust_step_ff);
      if ($signed(drive_x_in) > $signed(lim_in)) begin
         clamp_in = lim_in;
      end else if ($signed(drive_x_in) < $signed(nlim_in)) begin
         clamp_in = nlim_in;
      end else begin
         clamp_in = drive_x_in;
      end
      pol_in = invert_ff ? ('0 - clamp_in) : clamp_in;
      abs_in = pol_in[DRIVE_BITS] ? ('0 - pol_in) : pol_in;
   end

   esr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.spd_start | cmd.duty_start),
      .dividend (div_a_in),
      .divisor  (div_b_in),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_power_ff    <= POWER_BITS'(255);
         adjust_step_ff  <= POWER_BITS'(1);
         min_interval_ff <= INTERVAL_BITS'(10);
         invert_ff       <= 1'b0;
         target_ff       <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAX_POWER:    max_power_ff    <= csr_wdata[POWER_BITS-1:0];
            CSR_ADJUST_STEP:  adjust_step_ff  <= csr_wdata[POWER_BITS-1:0];
            CSR_MIN_INTERVAL: min_interval_ff <= csr_wdata[INTERVAL_BITS-1:0];
            CSR_INVERT:       invert_ff       <= csr_wdata[0];
            CSR_TARGET_SPEED: target_ff       <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_count_ff  <= '0;
         prev_count_ff <= '0;
         prev_time_ff  <= '0;
         speed_ff      <= '0;
         drive_ff      <= '0;
         duty_ff       <= '0;
         dir_ff        <= 1'b0;
         taken_ff      <= 1'b0;
         written_ff    <= 1'b0;
      end else begin
         if (cmd.capture) begin
            taken_ff   <= 1'b0;
            written_ff <= 1'b0;
         end
         if (cmd.count_edge) begin
            if (line_a_ff == line_b_ff) begin
               raw_count_ff <= raw_count_ff + COUNT_BITS'(1);
            end else begin
               raw_count_ff <= raw_count_ff - COUNT_BITS'(1);
            end
         end
         if (cmd.count_clear) begin
            raw_count_ff <= '0;
         end
         if (cmd.spd_load) begin
            speed_ff      <= den_zero_ff ? 32'd0 : q_signed_in;
            prev_time_ff  <= time_ff;
            prev_count_ff <= cur_ff;
            taken_ff      <= 1'b1;
         end
         if (cmd.drive_up) begin
            drive_ff   <= ($signed(up_in) < $signed(lim_in)) ?
                          up_in[DRIVE_BITS-1:0] : lim_in[DRIVE_BITS-1:0];
            written_ff <= 1'b1;
         end
         if (cmd.drive_down) begin
            drive_ff   <= ($signed(down_in) > $signed(nlim_in)) ?
                          down_in[DRIVE_BITS-1:0] : nlim_in[DRIVE_BITS-1:0];
            written_ff <= 1'b1;
         end
         if (cmd.drive_zero) begin
            drive_ff   <= '0;
            written_ff <= 1'b1;
         end
         if (cmd.duty_load) begin
            duty_ff <= (max_power_ff == '0) ? 8'd0 : div_q[7:0];
            dir_ff  <= dir_next_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= in_mode;
         line_a_ff <= in_line_a;
         line_b_ff <= in_line_b;
         time_ff   <= in_time_ms;
      end
      if (cmd.prep) begin
         cur_ff   <= logical_in;
         delta_ff <= time_ff - prev_time_ff;
      end
      if (cmd.diff) begin
         diff_ff <= cur_ff - prev_count_ff;
      end
      if (cmd.scale) begin
         num_ff <= scaled_in;
      end
      if (cmd.spd_start) begin
         neg_ff      <= num_ff[31] ^ delta_ff[31];
         den_zero_ff <= (delta_ff == '0);
      end
      if (cmd.map) begin
         dir_next_ff <= !pol_in[DRIVE_BITS] && (pol_in != '0);
         mag_ff      <= abs_in[POWER_BITS-1:0];
      end
      if (cmd.prod) begin
         prod_ff <= PROD_BITS'(mag_ff * DUTY_MAX);
      end
      if (cmd.out_load) begin
         rsp_duty_ff    <= duty_ff;
         rsp_dir_ff     <= dir_ff;
         rsp_speed_ff   <= speed_ff;
         rsp_count_ff   <= logical_in;
         rsp_taken_ff   <= taken_ff;
         rsp_written_ff <= written_ff;
      end
   end

   always_comb begin
      stat.mode        = mode_ff;
      stat.interval_ok = (delta_ff >= 32'(min_interval_ff));
      stat.target_zero = (target_ff == '0);
      stat.speed_lt    = ($signed(speed_ff) < $signed(target_ff));
      stat.speed_gt    = ($signed(speed_ff) > $signed(target_ff));
      stat.div_done    = div_done;
   end

   assign out_pwm_duty      = rsp_duty_ff;
   assign out_direction     = rsp_dir_ff;
   assign out_speed         = rsp_speed_ff;
   assign out_count         = rsp_count_ff;
   assign out_sample_taken  = rsp_taken_ff;
   assign out_drive_written = rsp_written_ff;

endmodule

// ----- rtl/core/esr_ctrl.sv -----
// Controller state machine of the regulator: sequences one item through the datapath.
// Depends on esr_pkg for the command and status structs.
module esr_ctrl import esr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_DIFF,
      ST_SCALE,
      ST_SPD_START,
      ST_SPD_WAIT,
      ST_COMPARE,
      ST_MAP,
      ST_PROD,
      ST_DUTY_START,
      ST_DUTY_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.prep = 1'b1;
            state_in = ST_FINISH;
            case (stat.mode)
               MODE_EDGE:   cmd.count_edge  = 1'b1;
               MODE_CLEAR:  cmd.count_clear = 1'b1;
               MODE_SAMPLE: state_in        = ST_CHECK;
               default: ;
            endcase
         end
         ST_CHECK: begin
            state_in = stat.interval_ok ? ST_DIFF : ST_FINISH;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_SPD_START;
         end
         ST_SPD_START: begin
            cmd.spd_start = 1'b1;
            state_in      = ST_SPD_WAIT;
         end
         ST_SPD_WAIT: begin
            if (stat.div_done) begin
               cmd.spd_load = 1'b1;
               state_in     = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_MAP;
            if (stat.target_zero) begin
               cmd.drive_zero = 1'b1;
            end else if (stat.speed_lt) begin
               cmd.drive_up = 1'b1;
            end else if (stat.speed_gt) begin
               cmd.drive_down = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_DUTY_START;
         end
         ST_DUTY_START: begin
            cmd.duty_start = 1'b1;
            state_in       = ST_DUTY_WAIT;
         end
         ST_DUTY_WAIT: begin
            if (stat.div_done) begin
               cmd.duty_load = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
